FILE: rtl/vilr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vilr_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = 5;
   localparam int ID_W        = 10;
   localparam int WORD_W      = 63;
   localparam int SGI_LIMIT   = 16;

   // bit positions of the list word
   localparam int PID_LSB     = 32;
   localparam int GROUP_BIT   = 60;
   localparam int HW_BIT      = 61;
   localparam int PENDING_BIT = 62;

   localparam logic [1:0] MODE_INJECT = 2'd0;
   localparam logic [1:0] MODE_TAKE   = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_DUPLICATE  = 2'd1;
   localparam logic [1:0] STATUS_NO_EMPTY   = 2'd2;
   localparam logic [1:0] STATUS_NO_PENDING = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_RESP
   } state_type;

   // write side of the entry table
   typedef struct packed {
      logic              fill;
      logic              drop;
      logic              clear_all;
      logic [IDX_W-1:0]  idx;
      logic [ID_W-1:0]   id;
   } tbl_ctrl_type;

endpackage

`default_nettype wire

FILE: rtl/vilr_entry_table.sv
`timescale 1ns / 1ps
`default_nettype none

module vilr_entry_table (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire vilr_pkg::tbl_ctrl_type      ctrl,
   input  wire logic [vilr_pkg::IDX_W-1:0]  rd_idx,
   input  wire logic [vilr_pkg::CNT_W-1:0]  scan_n,
   output logic                             rd_valid,
   output logic [vilr_pkg::ID_W-1:0]        rd_id,
   output logic                             any_pending
);

   logic [vilr_pkg::MAX_ENTRIES-1:0] valid_ff;
   logic [vilr_pkg::MAX_ENTRIES-1:0] valid_in;
   logic [vilr_pkg::ID_W-1:0]        id_ff [vilr_pkg::MAX_ENTRIES];

   // update valid flags: clear all, fill or drop one entry
   always_comb begin
      valid_in = valid_ff;
      if (ctrl.clear_all) begin
         valid_in = '0;
      end else if (ctrl.fill) begin
         valid_in[ctrl.idx] = 1'b1;
      end else if (ctrl.drop) begin
         valid_in[ctrl.idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // store the interrupt number of a filled entry
   always_ff @(posedge clock) begin
      if (ctrl.fill) begin
         id_ff[ctrl.idx] <= ctrl.id;
      end
   end

   // read the entry under the scan pointer
   assign rd_valid = valid_ff[rd_idx];
   assign rd_id    = id_ff[rd_idx];

   // flag any occupied entry among the scanned ones
   always_comb begin
      any_pending = 1'b0;
      for (int i = 0; i < vilr_pkg::MAX_ENTRIES; i++) begin
         if (valid_ff[i] && (vilr_pkg::CNT_W'(i) < scan_n)) begin
            any_pending = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/virtual_irq_list_register_manager_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Inject scans all n = entries_in_use entries, one per cycle, through a single
// ID comparator. Take stops at the first occupied entry; clear-all and unused
// modes skip the scan. A new request is taken only once the previous response
// has been accepted.
// Reset (synchronous): all entries empty, entries_in_use = 16, no response pending.
module virtual_irq_list_register_manager_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [1:0]                   req_mode,
   input  wire logic [vilr_pkg::ID_W-1:0]    req_irq_id,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [vilr_pkg::IDX_W-1:0]        rsp_slot,
   output logic [vilr_pkg::ID_W-1:0]         rsp_irq_out,
   output logic [vilr_pkg::WORD_W-1:0]       rsp_entry_word,
   output logic                              rsp_any_pending,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [vilr_pkg::CNT_W-1:0]   csr_data
);

   vilr_pkg::state_type              state_ff, state_in;
   logic [vilr_pkg::CNT_W-1:0]       n_ff, n_in;
   logic [1:0]                       mode_ff, mode_in;
   logic [vilr_pkg::ID_W-1:0]        id_ff, id_in;
   logic [vilr_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic                             found_ff, found_in;
   logic                             dup_ff, dup_in;
   logic                             hit_ff, hit_in;
   logic [vilr_pkg::IDX_W-1:0]       pos_ff, pos_in;
   logic [vilr_pkg::ID_W-1:0]        take_id_ff, take_id_in;
   logic [1:0]                       status_ff, status_in;
   logic [vilr_pkg::IDX_W-1:0]       slot_ff, slot_in;
   logic [vilr_pkg::ID_W-1:0]        irq_ff, irq_in;
   logic [vilr_pkg::WORD_W-1:0]      word_ff, word_in;

   logic                             req_fire;
   logic                             scan_last;
   logic                             needs_scan;
   logic                             rd_valid;
   logic [vilr_pkg::ID_W-1:0]        rd_id;
   logic                             any_pending;
   vilr_pkg::tbl_ctrl_type           tbl_ctrl;

   assign req_fire   = req_valid && req_ready;
   assign scan_last  = (({1'b0, idx_ff} + vilr_pkg::CNT_W'(1)) == n_ff);
   assign needs_scan = ((req_mode == vilr_pkg::MODE_INJECT) ||
                        (req_mode == vilr_pkg::MODE_TAKE)) && (n_ff != '0);

   vilr_entry_table u_table (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (tbl_ctrl),
      .rd_idx      (idx_ff),
      .scan_n      (n_ff),
      .rd_valid    (rd_valid),
      .rd_id       (rd_id),
      .any_pending (any_pending)
   );

   // saturate the entry count on write
   assign csr_ready = 1'b1;
   always_comb begin
      n_in = n_ff;
      if (csr_valid && csr_ready) begin
         n_in = (csr_data > vilr_pkg::CNT_W'(vilr_pkg::MAX_ENTRIES)) ?
                vilr_pkg::CNT_W'(vilr_pkg::MAX_ENTRIES) : csr_data;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vilr_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = needs_scan ? vilr_pkg::ST_SCAN : vilr_pkg::ST_FINISH;
            end
         end
         vilr_pkg::ST_SCAN: begin
            if (scan_last || ((mode_ff == vilr_pkg::MODE_TAKE) && rd_valid)) begin
               state_in = vilr_pkg::ST_FINISH;
            end
         end
         vilr_pkg::ST_FINISH: begin
            state_in = vilr_pkg::ST_RESP;
         end
         vilr_pkg::ST_RESP: begin
            if (rsp_ready) begin
               state_in = vilr_pkg::ST_IDLE;
            end
         end
         default: state_in = vilr_pkg::ST_IDLE;
      endcase
   end

   // handshake outputs
   assign req_ready       = (state_ff == vilr_pkg::ST_IDLE);
   assign rsp_valid       = (state_ff == vilr_pkg::ST_RESP);
   assign rsp_status      = status_ff;
   assign rsp_slot        = slot_ff;
   assign rsp_irq_out     = irq_ff;
   assign rsp_entry_word  = word_ff;
   assign rsp_any_pending = any_pending;

   // scan, table update and result composition
   always_comb begin
      mode_in    = mode_ff;
      id_in      = id_ff;
      idx_in     = idx_ff;
      found_in   = found_ff;
      dup_in     = dup_ff;
      hit_in     = hit_ff;
      pos_in     = pos_ff;
      take_id_in = take_id_ff;
      status_in  = status_ff;
      slot_in    = slot_ff;
      irq_in     = irq_ff;
      word_in    = word_ff;
      tbl_ctrl   = '0;
      tbl_ctrl.idx = pos_ff;
      tbl_ctrl.id  = id_ff;
      unique case (state_ff)
         vilr_pkg::ST_IDLE: begin
            if (req_fire) begin
               mode_in  = req_mode;
               id_in    = req_irq_id;
               idx_in   = '0;
               found_in = 1'b0;
               dup_in   = 1'b0;
               hit_in   = 1'b0;
               pos_in   = '0;
            end
         end
         vilr_pkg::ST_SCAN: begin
            idx_in = idx_ff + vilr_pkg::IDX_W'(1);
            if (mode_ff == vilr_pkg::MODE_TAKE) begin
               if (rd_valid) begin
                  hit_in     = 1'b1;
                  pos_in     = idx_ff;
                  take_id_in = rd_id;
               end
            end else if (!rd_valid) begin
               if (!found_ff) begin
                  found_in = 1'b1;
                  pos_in   = idx_ff;
               end
            end else if (rd_id == id_ff) begin
               dup_in = 1'b1;
            end
         end
         vilr_pkg::ST_FINISH: begin
            status_in = vilr_pkg::STATUS_OK;
            slot_in   = '0;
            irq_in    = '0;
            word_in   = '0;
            unique case (mode_ff)
               vilr_pkg::MODE_INJECT: begin
                  if (dup_ff) begin
                     status_in = vilr_pkg::STATUS_DUPLICATE;
                  end else if (!found_ff) begin
                     status_in = vilr_pkg::STATUS_NO_EMPTY;
                  end else begin
                     tbl_ctrl.fill = 1'b1;
                     slot_in = pos_ff;
                     word_in[vilr_pkg::ID_W-1:0]    = id_ff;
                     word_in[vilr_pkg::GROUP_BIT]   = 1'b1;
                     word_in[vilr_pkg::PENDING_BIT] = 1'b1;
                     if (id_ff >= vilr_pkg::ID_W'(vilr_pkg::SGI_LIMIT)) begin
                        word_in[vilr_pkg::HW_BIT] = 1'b1;
                        word_in[vilr_pkg::PID_LSB +: vilr_pkg::ID_W] = id_ff;
                     end
                  end
               end
               vilr_pkg::MODE_TAKE: begin
                  if (hit_ff) begin
                     tbl_ctrl.drop = 1'b1;
                     slot_in = pos_ff;
                     irq_in  = take_id_ff;
                  end else begin
                     status_in = vilr_pkg::STATUS_NO_PENDING;
                  end
               end
               vilr_pkg::MODE_CLEAR: begin
                  tbl_ctrl.clear_all = 1'b1;
               end
               default: begin
               end
            endcase
         end
         vilr_pkg::ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vilr_pkg::ST_IDLE;
         n_ff     <= vilr_pkg::CNT_W'(vilr_pkg::MAX_ENTRIES);
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      id_ff      <= id_in;
      idx_ff     <= idx_in;
      found_ff   <= found_in;
      dup_ff     <= dup_in;
      hit_ff     <= hit_in;
      pos_ff     <= pos_in;
      take_id_ff <= take_id_in;
      status_ff  <= status_in;
      slot_ff    <= slot_in;
      irq_ff     <= irq_in;
      word_ff    <= word_in;
   end

   // no new request while a response waits
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while a response is pending");

   // an accepted request makes the block busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("block still ready after accepting a request");

   // a successful inject always carries the pending bit
   a_inject_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (mode_ff == vilr_pkg::MODE_INJECT) && (rsp_status == vilr_pkg::STATUS_OK)
      |-> rsp_entry_word[vilr_pkg::PENDING_BIT] && rsp_any_pending)
      else $error("inject response without pending entry");

   // nothing pending means no scanned entry is occupied
   a_no_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == vilr_pkg::STATUS_NO_PENDING) |-> !rsp_any_pending)
      else $error("take found nothing while entries are pending");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = vilr_pkg::MAX_ENTRIES + 4;
   localparam int SEGMENTS      = 10;
   localparam int SEG_ITEMS     = 170;
   localparam int REPORT_MAX    = 10;

   typedef struct packed {
      logic [1:0]                  status;
      logic [vilr_pkg::IDX_W-1:0]  slot;
      logic [vilr_pkg::ID_W-1:0]   irq;
      logic [vilr_pkg::WORD_W-1:0] word;
      logic                        pend;
   } lr_result_type;

   // Track the list table and the responses it should produce.
   class lr_scoreboard;
      bit                        occupied [vilr_pkg::MAX_ENTRIES];
      logic [vilr_pkg::ID_W-1:0] held_id  [vilr_pkg::MAX_ENTRIES];
      int unsigned               scan_limit;
      lr_result_type             expected_q [$];
      int unsigned               mismatches;

      function new();
         foreach (occupied[i]) begin
            occupied[i] = 1'b0;
            held_id[i]  = '0;
         end
         scan_limit = vilr_pkg::MAX_ENTRIES;
         mismatches = 0;
      endfunction

      // Saturate the entry count at the table size.
      function void set_scan(logic [vilr_pkg::CNT_W-1:0] v);
         scan_limit = (v > vilr_pkg::MAX_ENTRIES) ? vilr_pkg::MAX_ENTRIES : v;
      endfunction

      function bit any_held();
         for (int i = 0; i < scan_limit; i++)
            if (occupied[i]) return 1'b1;
         return 1'b0;
      endfunction

      // Apply one accepted request to the table and queue its response.
      function void log_request(logic [1:0] mode, logic [vilr_pkg::ID_W-1:0] id);
         lr_result_type r;
         int            free_at;
         bit            dup;
         bit            found;
         r       = '0;
         free_at = -1;
         dup     = 1'b0;
         found   = 1'b0;
         r.status = vilr_pkg::STATUS_OK;
         case (mode)
            vilr_pkg::MODE_INJECT: begin
               // A duplicate anywhere in the scanned entries wins over a free one.
               for (int i = 0; i < scan_limit; i++) begin
                  if (!occupied[i]) begin
                     if (free_at < 0) free_at = i;
                  end else if (held_id[i] == id) begin
                     dup = 1'b1;
                  end
               end
               if (dup) begin
                  r.status = vilr_pkg::STATUS_DUPLICATE;
               end else if (free_at < 0) begin
                  r.status = vilr_pkg::STATUS_NO_EMPTY;
               end else begin
                  occupied[free_at] = 1'b1;
                  held_id[free_at]  = id;
                  r.slot = vilr_pkg::IDX_W'(free_at);
                  r.word[vilr_pkg::ID_W-1:0]    = id;
                  r.word[vilr_pkg::GROUP_BIT]   = 1'b1;
                  r.word[vilr_pkg::PENDING_BIT] = 1'b1;
                  if (id >= vilr_pkg::SGI_LIMIT) begin
                     r.word[vilr_pkg::HW_BIT]                        = 1'b1;
                     r.word[vilr_pkg::PID_LSB +: vilr_pkg::ID_W]     = id;
                  end
               end
            end
            vilr_pkg::MODE_TAKE: begin
               r.status = vilr_pkg::STATUS_NO_PENDING;
               for (int i = 0; i < scan_limit; i++) begin
                  if (!found && occupied[i]) begin
                     found       = 1'b1;
                     r.status    = vilr_pkg::STATUS_OK;
                     r.slot      = vilr_pkg::IDX_W'(i);
                     r.irq       = held_id[i];
                     occupied[i] = 1'b0;
                     held_id[i]  = '0;
                  end
               end
            end
            vilr_pkg::MODE_CLEAR: begin
               // Clear drops unscanned entries too.
               foreach (occupied[i]) begin
                  occupied[i] = 1'b0;
                  held_id[i]  = '0;
               end
            end
            default: ;
         endcase
         r.pend = any_held();
         expected_q.push_back(r);
      endfunction

      function void note_failure();
         mismatches++;
      endfunction

      // Compare one accepted response with the oldest queued one.
      function void check_response(lr_result_type got);
         lr_result_type exp;
         if (expected_q.size() == 0) begin
            note_failure();
            if (mismatches <= REPORT_MAX)
               $display("unexpected response at %0t: status %0d slot %0d irq %0d",
                        $time, got.status, got.slot, got.irq);
            return;
         end
         exp = expected_q.pop_front();
         if (got.status !== exp.status || got.slot !== exp.slot || got.irq !== exp.irq ||
             got.word !== exp.word || got.pend !== exp.pend) begin
            note_failure();
            if (mismatches <= REPORT_MAX) begin
               $display("mismatch at %0t:", $time);
               if (got.status !== exp.status)
                  $display("  status   exp %0d got %0d", exp.status, got.status);
               if (got.slot !== exp.slot)
                  $display("  slot     exp %0d got %0d", exp.slot, got.slot);
               if (got.irq !== exp.irq)
                  $display("  irq_out  exp %0d got %0d", exp.irq, got.irq);
               if (got.word !== exp.word)
                  $display("  word     exp %h got %h", exp.word, got.word);
               if (got.pend !== exp.pend)
                  $display("  pending  exp %0d got %0d", exp.pend, got.pend);
            end
         end
      endfunction
   endclass

   logic                        clock       = 1'b0;
   logic                        reset       = 1'b1;
   logic                        req_valid   = 1'b0;
   logic                        req_ready;
   logic [1:0]                  req_mode    = vilr_pkg::MODE_INJECT;
   logic [vilr_pkg::ID_W-1:0]   req_irq_id  = '0;
   logic                        rsp_valid;
   logic                        rsp_ready   = 1'b0;
   logic [1:0]                  rsp_status;
   logic [vilr_pkg::IDX_W-1:0]  rsp_slot;
   logic [vilr_pkg::ID_W-1:0]   rsp_irq_out;
   logic [vilr_pkg::WORD_W-1:0] rsp_entry_word;
   logic                        rsp_any_pending;
   logic                        csr_valid   = 1'b0;
   logic                        csr_ready;
   logic [vilr_pkg::CNT_W-1:0]  csr_data    = '0;

   int unsigned                 cycle_count = 0;
   int unsigned                 req_gap_pct = 0;
   int unsigned                 rsp_stall_pct = 0;
   logic [vilr_pkg::ID_W-1:0]   id_pool [8];
   lr_scoreboard                lr_sb;

   virtual_irq_list_register_manager_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_irq_id      (req_irq_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_irq_out     (rsp_irq_out),
      .rsp_entry_word  (rsp_entry_word),
      .rsp_any_pending (rsp_any_pending),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Bound the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** virtual_irq_list_register_manager_unit: FAILED **");
         $finish;
      end
   end

   // Check accepted responses, then pick the next ready level.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         lr_sb.check_response('{rsp_status, rsp_slot, rsp_irq_out, rsp_entry_word,
                                rsp_any_pending});
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= rsp_stall_pct);
   end

   // Present one request and hold it until accepted.
   task automatic send_request(input logic [1:0] mode,
                               input logic [vilr_pkg::ID_W-1:0] id);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_irq_id <= id;
      do @(posedge clock); while (!req_ready);
      lr_sb.log_request(mode, id);
   endtask

   // Drop valid and wait for every outstanding response.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (lr_sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_entry_count(input logic [vilr_pkg::CNT_W-1:0] v);
      drain_responses();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      lr_sb.set_scan(v);
   endtask

   // Mixes injects with other modes, drawing half the IDs from a small pool so duplicates and a full table show up.
   task automatic random_request(input int unsigned inject_pct);
      int unsigned               roll;
      logic [vilr_pkg::ID_W-1:0] id;
      roll = $urandom_range(99);
      if ($urandom_range(1))
         id = id_pool[$urandom_range(7)];
      else if ($urandom_range(3) == 0)
         id = vilr_pkg::ID_W'($urandom_range(vilr_pkg::SGI_LIMIT - 1));
      else
         id = vilr_pkg::ID_W'($urandom_range(1023));
      if (roll < inject_pct)
         send_request(vilr_pkg::MODE_INJECT, id);
      else if (roll < 95)
         send_request(vilr_pkg::MODE_TAKE, vilr_pkg::ID_W'($urandom_range(1023)));
      else if (roll < 98)
         send_request(vilr_pkg::MODE_CLEAR, vilr_pkg::ID_W'($urandom_range(1023)));
      else
         send_request(MODE_UNUSED, vilr_pkg::ID_W'($urandom_range(1023)));
   endtask

   initial begin
      logic [vilr_pkg::CNT_W-1:0] seg_count [SEGMENTS];
      int unsigned                seg_len;
      int unsigned                inject_pct;
      seg_count = '{5'd1, 5'd16, 5'd0, 5'd4, 5'd31, 5'd2, 5'd17, 5'd8, 5'd12, 5'd16};
      seg_count[SEGMENTS-1] =
         vilr_pkg::CNT_W'($urandom_range(1, vilr_pkg::MAX_ENTRIES));
      lr_sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: full table scan after reset.
      send_request(vilr_pkg::MODE_TAKE, 10'd0);
      send_request(vilr_pkg::MODE_INJECT, 10'd0);
      send_request(vilr_pkg::MODE_INJECT, 10'd15);
      send_request(vilr_pkg::MODE_INJECT, 10'd16);
      send_request(vilr_pkg::MODE_INJECT, 10'd1023);
      send_request(vilr_pkg::MODE_INJECT, 10'h2AA);
      send_request(vilr_pkg::MODE_INJECT, 10'h155);
      send_request(vilr_pkg::MODE_INJECT, 10'd16);
      send_request(MODE_UNUSED, 10'd1023);
      send_request(vilr_pkg::MODE_TAKE, 10'd1023);
      send_request(vilr_pkg::MODE_INJECT, 10'd7);
      send_request(vilr_pkg::MODE_CLEAR, 10'd0);
      send_request(vilr_pkg::MODE_TAKE, 10'd0);

      // Directed: two entries, full table, duplicate behind a free entry.
      write_entry_count(5'd2);
      send_request(vilr_pkg::MODE_INJECT, 10'd100);
      send_request(vilr_pkg::MODE_INJECT, 10'd200);
      send_request(vilr_pkg::MODE_INJECT, 10'd300);
      send_request(vilr_pkg::MODE_TAKE, 10'd0);
      send_request(vilr_pkg::MODE_INJECT, 10'd200);

      // Directed: nothing scanned, then an oversized count.
      write_entry_count(5'd0);
      send_request(vilr_pkg::MODE_INJECT, 10'd1);
      send_request(vilr_pkg::MODE_TAKE, 10'd0);
      write_entry_count(5'd31);
      send_request(vilr_pkg::MODE_TAKE, 10'd0);

      // Random segments, one entry count each, across three idling phases.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         write_entry_count(seg_count[seg]);
         if (seg < 4) begin
            req_gap_pct   = 9;
            rsp_stall_pct = 45;
         end else if (seg < 7) begin
            req_gap_pct   = 45;
            rsp_stall_pct = 9;
         end else begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end
         foreach (id_pool[i])
            id_pool[i] = (i < 3) ?
                         vilr_pkg::ID_W'($urandom_range(vilr_pkg::SGI_LIMIT - 1)) :
                         vilr_pkg::ID_W'($urandom_range(1023));
         inject_pct = $urandom_range(45, 75);
         seg_len    = (seg_count[seg] == 0) ? 20 : SEG_ITEMS;
         for (int n = 0; n < seg_len; n++)
            random_request(inject_pct);
      end

      drain_responses();
      if (lr_sb.mismatches == 0 && lr_sb.expected_q.size() == 0)
         $display("** virtual_irq_list_register_manager_unit: PASSED **");
      else
         $display("** virtual_irq_list_register_manager_unit: FAILED **");
      $finish;
   end

endmodule
